[src/sha_pkg.sv]
`timescale 1ns / 1ps
package sha_pkg;

    localparam int WordW   = 32;
    localparam int RoundsN = 64;

    typedef logic [WordW-1:0] word_t;

    typedef struct packed {
        logic       load_byte;
        logic [7:0] byte_val;
        logic       pad_start;
        logic       pad_zero;
        logic       put_len;
        logic       comp_start;
        logic       comp_step;
        logic       comp_finish;
        logic       init_chain;
    } sha_cmd_t;

    typedef struct packed {
        logic [5:0] fill;
        logic       block_full;
        logic       round_last;
    } sha_stat_t;

    localparam word_t IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam word_t ROUND_K [RoundsN] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

endpackage

[src/sha256_stream_hasher.sv]
`timescale 1ns / 1ps
// SHA-256 over a byte stream.
// Input beats on s_axis: tdata carries one message byte, tuser bit 0 says
// whether that byte is present, tlast closes the message. A beat with no
// byte and tlast set hashes what was received so far (empty if nothing).
// A byte that does not fill a block is taken and the block stays ready for
// the next byte. The byte that fills a 64-byte block starts a compression,
// one round per cycle through a single round unit. After tlast, padding is
// written one byte per cycle (with a second padded block if fewer than 9
// bytes were free), then the length field and the rounds of the last block.
// The digest leaves on m_axis as four beats of 64 bits, most significant
// first; tuser holds the word index and tlast marks the fourth beat.
// The block takes no input while it compresses, pads or sends the digest;
// if the receiver stalls, the current digest beat simply holds.
// Reset returns the chaining value to the initial hash and clears the
// fill position and byte count; the block buffer is not cleared.
module sha256_stream_hasher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // byte_present
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // digest_word
    output logic [1:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast    // final_word
);
    import sha_pkg::*;

    sha_cmd_t     cmd;
    sha_stat_t    stat;
    logic [255:0] digest;
    logic [1:0]   idx;

    sha_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .in_byte       (s_axis_tdata),
        .in_present    (s_axis_tuser),
        .in_last       (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .out_index     (idx),
        .cmd           (cmd),
        .stat          (stat)
    );

    sha_datapath u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .digest (digest)
    );

    assign m_axis_tdata = digest[255 - 64*int'(idx) -: 64];
    assign m_axis_tuser = idx;
    assign m_axis_tlast = (idx == 2'd3);

endmodule

[src/sha_datapath.sv]
`timescale 1ns / 1ps
module sha_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  sha_pkg::sha_cmd_t cmd,
    output sha_pkg::sha_stat_t stat,
    output logic [255:0]      digest
);
    import sha_pkg::*;

    word_t      chain_reg [8];
    word_t      blk_reg   [16];
    word_t      v_reg     [8];
    logic [5:0] fill_reg;
    logic [60:0] total_reg;
    logic [5:0] round_reg;

    word_t s0, s1, w_new, t1, t2, big0, big1, ch, maj;
    logic [63:0] bits;
    logic [3:0]  widx;
    logic [4:0]  bsh;

    assign bits = {total_reg, 3'b000};
    assign widx = fill_reg[5:2];
    assign bsh  = 5'(24 - 8 * int'(fill_reg[1:0]));

    // message schedule from a 16-word window
    assign s0 = rotr(blk_reg[1], 7) ^ rotr(blk_reg[1], 18) ^ (blk_reg[1] >> 3);
    assign s1 = rotr(blk_reg[14], 17) ^ rotr(blk_reg[14], 19) ^ (blk_reg[14] >> 10);
    assign w_new = blk_reg[0] + s0 + blk_reg[9] + s1;

    assign big1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
    assign ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign t1   = v_reg[7] + big1 + ch + ROUND_K[round_reg] + blk_reg[0];
    assign big0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
    assign maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t2   = big0 + maj;

    assign stat.fill       = fill_reg;
    assign stat.block_full = (fill_reg == 6'd63);
    assign stat.round_last = (round_reg == 6'(RoundsN - 1));

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            digest[255 - 32*i -: 32] = chain_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            total_reg <= '0;
            round_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= IV[i];
            end
        end
        else
        begin
            if (cmd.load_byte || cmd.pad_start || cmd.pad_zero)
            begin
                blk_reg[widx] <= (blk_reg[widx] & ~(word_t'(8'hff) << bsh))
                    | (word_t'(cmd.load_byte ? cmd.byte_val
                                             : (cmd.pad_start ? PAD_BYTE : 8'h00)) << bsh);
                fill_reg <= fill_reg + 6'd1;
            end
            if (cmd.load_byte)
            begin
                total_reg <= total_reg + 61'd1;
            end
            if (cmd.put_len)
            begin
                blk_reg[14] <= bits[63:32];
                blk_reg[15] <= bits[31:0];
            end
            if (cmd.comp_start)
            begin
                round_reg <= '0;
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= chain_reg[i];
                end
            end
            if (cmd.comp_step)
            begin
                round_reg <= round_reg + 6'd1;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
                for (int i = 0; i < 15; i++)
                begin
                    blk_reg[i] <= blk_reg[i+1];
                end
                blk_reg[15] <= w_new;
            end
            if (cmd.comp_finish)
            begin
                // add the working values after the last round
                chain_reg[0] <= chain_reg[0] + t1 + t2;
                chain_reg[1] <= chain_reg[1] + v_reg[0];
                chain_reg[2] <= chain_reg[2] + v_reg[1];
                chain_reg[3] <= chain_reg[3] + v_reg[2];
                chain_reg[4] <= chain_reg[4] + v_reg[3] + t1;
                chain_reg[5] <= chain_reg[5] + v_reg[4];
                chain_reg[6] <= chain_reg[6] + v_reg[5];
                chain_reg[7] <= chain_reg[7] + v_reg[6];
            end
            if (cmd.init_chain)
            begin
                fill_reg  <= '0;
                total_reg <= '0;
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= IV[i];
                end
            end
        end
    end

endmodule

[src/sha_ctrl.sv]
`timescale 1ns / 1ps
module sha_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         in_byte,
    input  logic               in_present,
    input  logic               in_last,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [1:0]         out_index,
    output sha_pkg::sha_cmd_t  cmd,
    input  sha_pkg::sha_stat_t stat
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ROUND, ST_PAD, ST_LEN, ST_FINAL_ROUND, ST_OUT
    } state_t;

    state_t     state_reg;
    logic       last_reg;
    logic       pend_pad_reg;
    logic       wrap_reg;
    logic [1:0] idx_reg;
    logic       accept;
    logic       wrap_now;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign out_index     = idx_reg;
    assign wrap_now      = !pend_pad_reg && (stat.fill == 6'd0) && !wrap_reg;

    always_comb
    begin
        cmd = '0;
        cmd.byte_val = in_byte;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_present)
                begin
                    cmd.load_byte  = 1'b1;
                    cmd.comp_start = stat.block_full;
                end
            end
            ST_ROUND, ST_FINAL_ROUND:
            begin
                cmd.comp_step   = 1'b1;
                cmd.comp_finish = 1'b0;
            end
            ST_PAD:
            begin
                cmd.pad_start = pend_pad_reg;
                cmd.pad_zero  = !pend_pad_reg && (stat.fill != 6'd56) && !wrap_now;
            end
            ST_LEN:
            begin
                cmd.put_len    = 1'b1;
                cmd.comp_start = 1'b1;
            end
            ST_OUT:
            begin
                cmd.init_chain = m_axis_tready && (idx_reg == 2'd3);
            end
            default:
            begin
            end
        endcase
        if ((state_reg == ST_ROUND || state_reg == ST_FINAL_ROUND) && stat.round_last)
        begin
            cmd.comp_finish = 1'b1;
        end
        if (state_reg == ST_PAD && wrap_now)
        begin
            cmd.comp_start = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            last_reg     <= 1'b0;
            pend_pad_reg <= 1'b0;
            wrap_reg     <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg     <= in_last;
                        pend_pad_reg <= 1'b1;
                        wrap_reg     <= 1'b0;
                        idx_reg      <= '0;
                        if (in_present && stat.block_full)
                        begin
                            state_reg <= ST_ROUND;
                        end
                        else if (in_last)
                        begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_ROUND:
                begin
                    if (stat.round_last)
                    begin
                        state_reg <= last_reg ? ST_PAD : ST_IDLE;
                    end
                end
                ST_PAD:
                begin
                    // first the pad byte, then zeros up to the length field
                    pend_pad_reg <= 1'b0;
                    if (!pend_pad_reg)
                    begin
                        if (wrap_now)
                        begin
                            last_reg  <= 1'b1;
                            wrap_reg  <= 1'b1;
                            state_reg <= ST_ROUND;
                        end
                        else if (stat.fill == 6'd56)
                        begin
                            state_reg <= ST_LEN;
                        end
                    end
                end
                ST_LEN:
                begin
                    state_reg <= ST_FINAL_ROUND;
                end
                ST_FINAL_ROUND:
                begin
                    if (stat.round_last)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        idx_reg <= idx_reg + 2'd1;
                        if (idx_reg == 2'd3)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[src/sha_checker.sv]
`timescale 1ns / 1ps
module sha_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // no input while a digest is going out
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready during digest output");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 2'd3)))
        else $error("tlast does not match word index");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled digest beat changed");

    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 2'd1)
        else $error("digest beats out of order");

endmodule

bind sha256_stream_hasher sha_checker u_sha_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
